### hdl/fts_pkg.sv
// shared types and constants for the frame time window statistics block
// no dependencies; fts_if and frame_time_window_stats in hdl/ refer to this package by scoped name
package fts_pkg;

  localparam int FIELD_W    = 24;
  localparam int RATE_W     = 16;
  localparam int WLEN_W     = 7;
  localparam int ELAPSED_W  = 26;
  localparam int FRAMES_W   = 16;
  localparam int COUNT_W    = 40;
  localparam int NUM_COUNTS = 5;
  localparam int CNT_IDX_W  = 3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [WLEN_W-1:0]  WLEN_RESET = 7'd10;
  localparam logic [FIELD_W-1:0] UPD_RESET  = 24'd333000;

  // register select, taken from the word address bit of paddr
  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_UPDATE_INTERVAL = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] frame_time;
    logic [FIELD_W-1:0] gap_time;
    logic [FIELD_W-1:0] polygon_count;
    logic [FIELD_W-1:0] line_count;
    logic [FIELD_W-1:0] ttf_count;
    logic [FIELD_W-1:0] stf_count;
    logic [FIELD_W-1:0] point_count;
  } fts_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] window_mean_time;
    logic               update_valid;
    logic [FIELD_W-1:0] interval_frame_time;
    logic [RATE_W-1:0]  frame_rate_x16;
    logic [FIELD_W-1:0] avg_polygons;
    logic [FIELD_W-1:0] avg_lines;
    logic [FIELD_W-1:0] avg_ttfs;
    logic [FIELD_W-1:0] avg_stfs;
    logic [FIELD_W-1:0] avg_points;
  } fts_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIM,
    S_EVICT,
    S_PUSH,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } fts_state_t;

  typedef enum logic [1:0] {
    OP_MEAN,
    OP_FTIME,
    OP_RATE,
    OP_COUNT
  } fts_op_t;

endpackage

### hdl/fts_if.sv
// valid/ready channels for frame events in and statistics out
// payload types come from fts_pkg
interface fts_in_if;
  logic            valid;
  logic            ready;
  fts_pkg::fts_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_out_if;
  logic             valid;
  logic             ready;
  fts_pkg::fts_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/fts_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module fts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fts_div.sv
// shared restoring divider, one quotient bit per cycle
// numerator arrives left-aligned so only the significant bits are stepped; no dependencies
module fts_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 26,
  localparam int STEP_W = $clog2(NUM_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [NUM_W-1:0]  quot
);

  logic              busy;
  logic [STEP_W-1:0] steps_left;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [NUM_W-1:0]  q;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_diff;
  logic              fits;
  logic [DEN_W-1:0]  rem_next;

  assign rem_sh   = {rem, q[NUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, den_r};
  assign fits     = rem_sh >= {1'b0, den_r};
  assign rem_next = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  assign quot     = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= steps;
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in from the bottom as numerator bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      q   <= {q[NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

### hdl/frame_time_window_stats.sv
// frame time window statistics: boxcar mean of recent frame times plus interval stats
// sequence: trim by evicting oldest entries, push, then divide for the window mean;
//   with an interval update also frame time, frame rate and the five count averages
// one event in flight at a time, paced by the shared bit-serial divider
// reset: window emptied, accumulators cleared, window_length 10, update_interval 333000
// depends on fts_pkg, fts_if, fts_ram and fts_div
module frame_time_window_stats #(
  parameter int MAX_WINDOW       = 64,
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fts_pkg::PADDR_W-1:0]   paddr,
  input  logic [fts_pkg::PDATA_W-1:0]   pwdata,
  output logic [fts_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  fts_in_if.sink                        frame,
  fts_out_if.source                     stats
);

  localparam int FIELD_W   = fts_pkg::FIELD_W;
  localparam int RATE_W    = fts_pkg::RATE_W;
  localparam int WLEN_W    = fts_pkg::WLEN_W;
  localparam int ELAPSED_W = fts_pkg::ELAPSED_W;
  localparam int FRAMES_W  = fts_pkg::FRAMES_W;
  localparam int COUNT_W   = fts_pkg::COUNT_W;
  localparam int NUM_CNT   = fts_pkg::NUM_COUNTS;
  localparam int CIDX_W    = fts_pkg::CNT_IDX_W;

  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W      = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int SUM_W      = FIELD_W + $clog2(MAX_WINDOW);
  localparam int RATE_NUM_W = $clog2(16 * TICKS_PER_SECOND) + FRAMES_W;
  localparam int DEN_W      = (CNT_W > ELAPSED_W) ? CNT_W : ELAPSED_W;
  localparam int DW_A       = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
  localparam int DW         = (DW_A > COUNT_W) ? DW_A : COUNT_W;
  localparam int STEP_W     = $clog2(DW + 1);

  localparam logic [RATE_NUM_W-1:0] RATE_MULT = RATE_NUM_W'(16 * TICKS_PER_SECOND);

  // configuration
  logic [WLEN_W-1:0]  window_length;
  logic [FIELD_W-1:0] update_interval;
  logic               cfg_write;

  // sequencer
  fts_pkg::fts_state_t state, state_next;
  fts_pkg::fts_op_t    op;
  logic [CIDX_W-1:0]   cnt_idx;

  // window and accumulators
  logic [IDX_W-1:0]     oldest_index;
  logic [CNT_W-1:0]     stored_count;
  logic [SUM_W-1:0]     window_sum;
  logic [ELAPSED_W-1:0] interval_elapsed;
  logic [FRAMES_W-1:0]  interval_frames;
  logic [COUNT_W-1:0]   cnt_acc [NUM_CNT];

  fts_pkg::fts_in_t    item;
  logic [FIELD_W-1:0]  item_cnt [NUM_CNT];
  logic [RATE_NUM_W-1:0] rate_num;

  // results
  logic [FIELD_W-1:0] res_mean;
  logic [FIELD_W-1:0] res_ftime;
  logic [RATE_W-1:0]  res_rate;
  logic [FIELD_W-1:0] res_avg [NUM_CNT];

  // control strobes
  logic in_take;
  logic evict_apply;
  logic push;
  logic div_start;
  logic div_capture;
  logic out_load;

  logic [LEN_W-1:0] wl_ext;
  logic [LEN_W-1:0] eff_len;
  logic             evict_need;
  logic             upd_hit;
  logic             last_op;
  logic [IDX_W:0]   slot_sum;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] oldest_inc;
  logic [FIELD_W-1:0] ram_rdata;

  logic [DW-1:0]     div_num;
  logic [DEN_W-1:0]  div_den;
  logic [STEP_W-1:0] div_steps;
  logic              div_done;
  logic [DW-1:0]     div_quot;

  logic [ELAPSED_W:0] elapsed_sum;
  logic [COUNT_W:0]   cnt_sum [NUM_CNT];

  function automatic logic [FIELD_W-1:0] sat_field(input logic [DW-1:0] v);
    sat_field = (|v[DW-1:FIELD_W]) ? '1 : v[FIELD_W-1:0];
  endfunction

  function automatic logic [RATE_W-1:0] sat_rate(input logic [DW-1:0] v);
    sat_rate = (|v[DW-1:RATE_W]) ? '1 : v[RATE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- apb
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // paddr[2] is the word select between the two registers
  always_comb begin
    unique case (paddr[2])
      fts_pkg::REG_WINDOW_LENGTH:   prdata = fts_pkg::PDATA_W'(window_length);
      fts_pkg::REG_UPDATE_INTERVAL: prdata = fts_pkg::PDATA_W'(update_interval);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= fts_pkg::WLEN_RESET;
      update_interval <= fts_pkg::UPD_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        fts_pkg::REG_WINDOW_LENGTH:   window_length   <= pwdata[WLEN_W-1:0];
        fts_pkg::REG_UPDATE_INTERVAL: update_interval <= pwdata[FIELD_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath helpers
  assign wl_ext = LEN_W'(window_length);

  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = wl_ext;
    end
  end

  assign evict_need = LEN_W'(stored_count) >= eff_len;
  assign upd_hit    = interval_elapsed > ELAPSED_W'(update_interval);
  assign last_op    = ((op == fts_pkg::OP_MEAN) && !upd_hit) ||
                      ((op == fts_pkg::OP_COUNT) && (cnt_idx == CIDX_W'(NUM_CNT - 1)));

  // both terms stay below the depth, so one subtract wraps the slot
  assign slot_sum   = (IDX_W + 1)'(oldest_index) + (IDX_W + 1)'(stored_count);
  assign slot       = (slot_sum >= (IDX_W + 1)'(MAX_WINDOW)) ?
                      IDX_W'(slot_sum - (IDX_W + 1)'(MAX_WINDOW)) : slot_sum[IDX_W-1:0];
  assign oldest_inc = (oldest_index == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_index + 1'b1;

  assign item_cnt[0] = item.polygon_count;
  assign item_cnt[1] = item.line_count;
  assign item_cnt[2] = item.ttf_count;
  assign item_cnt[3] = item.stf_count;
  assign item_cnt[4] = item.point_count;

  assign elapsed_sum = {1'b0, interval_elapsed} + (ELAPSED_W + 1)'(item.gap_time);

  for (genvar i = 0; i < NUM_CNT; i++) begin : g_cnt_sum
    assign cnt_sum[i] = {1'b0, cnt_acc[i]} + (COUNT_W + 1)'(item_cnt[i]);
  end

  fts_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (MAX_WINDOW)
  ) u_time_store (
    .clk   (clk),
    .we    (push),
    .waddr (slot),
    .wdata (item.frame_time),
    .raddr (oldest_index),
    .rdata (ram_rdata)
  );

  // divider operands, numerators left-aligned to skip known leading zeros
  always_comb begin
    unique case (op)
      fts_pkg::OP_MEAN: begin
        div_num   = DW'(window_sum) << (DW - SUM_W);
        div_den   = DEN_W'(stored_count);
        div_steps = STEP_W'(SUM_W);
      end
      fts_pkg::OP_FTIME: begin
        div_num   = DW'(interval_elapsed) << (DW - ELAPSED_W);
        div_den   = DEN_W'(interval_frames);
        div_steps = STEP_W'(ELAPSED_W);
      end
      fts_pkg::OP_RATE: begin
        div_num   = DW'(rate_num) << (DW - RATE_NUM_W);
        div_den   = DEN_W'(interval_elapsed);
        div_steps = STEP_W'(RATE_NUM_W);
      end
      fts_pkg::OP_COUNT: begin
        div_num   = DW'(cnt_acc[cnt_idx]) << (DW - COUNT_W);
        div_den   = DEN_W'(interval_frames);
        div_steps = STEP_W'(COUNT_W);
      end
    endcase
  end

  fts_div #(
    .NUM_W (DW),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .steps (div_steps),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      fts_pkg::S_IDLE:      if (frame.valid) state_next = fts_pkg::S_TRIM;
      fts_pkg::S_TRIM:      state_next = evict_need ? fts_pkg::S_EVICT : fts_pkg::S_PUSH;
      fts_pkg::S_EVICT:     state_next = fts_pkg::S_TRIM;
      fts_pkg::S_PUSH:      state_next = fts_pkg::S_DIV_START;
      fts_pkg::S_DIV_START: state_next = fts_pkg::S_DIV_WAIT;
      fts_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_next = last_op ? fts_pkg::S_FINISH : fts_pkg::S_DIV_START;
        end
      end
      fts_pkg::S_FINISH:    if (!stats.valid || stats.ready) state_next = fts_pkg::S_IDLE;
      default:              state_next = fts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    frame.ready = (state == fts_pkg::S_IDLE);
    in_take     = (state == fts_pkg::S_IDLE) && frame.valid;
    evict_apply = (state == fts_pkg::S_EVICT);
    push        = (state == fts_pkg::S_PUSH);
    div_start   = (state == fts_pkg::S_DIV_START);
    div_capture = (state == fts_pkg::S_DIV_WAIT) && div_done;
    out_load    = (state == fts_pkg::S_FINISH) && (!stats.valid || stats.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fts_pkg::S_IDLE;
      op      <= fts_pkg::OP_MEAN;
      cnt_idx <= '0;
    end else begin
      state <= state_next;
      if (in_take) begin
        op <= fts_pkg::OP_MEAN;
      end else if (div_capture) begin
        unique case (op)
          fts_pkg::OP_MEAN:  op <= fts_pkg::OP_FTIME;
          fts_pkg::OP_FTIME: op <= fts_pkg::OP_RATE;
          fts_pkg::OP_RATE: begin
            op      <= fts_pkg::OP_COUNT;
            cnt_idx <= '0;
          end
          fts_pkg::OP_COUNT: cnt_idx <= cnt_idx + 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- window and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_index     <= '0;
      stored_count     <= '0;
      window_sum       <= '0;
      interval_elapsed <= '0;
      interval_frames  <= '0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_acc[i] <= '0;
      end
    end else begin
      if (evict_apply) begin
        window_sum   <= window_sum - SUM_W'(ram_rdata);
        oldest_index <= oldest_inc;
        stored_count <= stored_count - 1'b1;
      end else if (push) begin
        window_sum   <= window_sum + SUM_W'(item.frame_time);
        stored_count <= stored_count + 1'b1;
      end

      if (push) begin
        interval_elapsed <= elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
        if (!(&interval_frames)) begin
          interval_frames <= interval_frames + 1'b1;
        end
        for (int i = 0; i < NUM_CNT; i++) begin
          cnt_acc[i] <= cnt_sum[i][COUNT_W] ? '1 : cnt_sum[i][COUNT_W-1:0];
        end
      end else if (out_load && upd_hit) begin
        interval_elapsed <= '0;
        interval_frames  <= '0;
        for (int i = 0; i < NUM_CNT; i++) begin
          cnt_acc[i] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= frame.data;
    end
    rate_num <= RATE_MULT * RATE_NUM_W'(interval_frames);
    if (div_capture) begin
      unique case (op)
        fts_pkg::OP_MEAN:  res_mean  <= sat_field(div_quot);
        fts_pkg::OP_FTIME: res_ftime <= sat_field(div_quot);
        fts_pkg::OP_RATE:  res_rate  <= sat_rate(div_quot);
        fts_pkg::OP_COUNT: res_avg[cnt_idx] <= sat_field(div_quot);
      endcase
    end
    if (out_load) begin
      stats.data.window_mean_time    <= res_mean;
      stats.data.update_valid        <= upd_hit;
      stats.data.interval_frame_time <= upd_hit ? res_ftime : '0;
      stats.data.frame_rate_x16      <= upd_hit ? res_rate : '0;
      stats.data.avg_polygons        <= upd_hit ? res_avg[0] : '0;
      stats.data.avg_lines           <= upd_hit ? res_avg[1] : '0;
      stats.data.avg_ttfs            <= upd_hit ? res_avg[2] : '0;
      stats.data.avg_stfs            <= upd_hit ? res_avg[3] : '0;
      stats.data.avg_points          <= upd_hit ? res_avg[4] : '0;
    end
  end

  // output register: holds the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (out_load) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == fts_pkg::S_PUSH) |-> (LEN_W'(stored_count) < eff_len))
    else $error("window still full when pushing a frame time");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> !frame.ready)
    else $error("new event accepted while one is in progress");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == fts_pkg::S_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_clear_after_update: assert property (@(posedge clk) disable iff (rst)
    (out_load && upd_hit) |=> ((interval_elapsed == '0) && (interval_frames == '0)))
    else $error("interval accumulators not cleared after an update");

endmodule

### verif/tb_top.sv
// self-checking bench for frame_time_window_stats: directed table, then random phases
// compares results to an in-bench boxcar mean and interval model, except typed rows
// depends on fts_pkg, fts_if and frame_time_window_stats from hdl/
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W    = fts_pkg::FIELD_W;
  localparam int RATE_W     = fts_pkg::RATE_W;
  localparam int WLEN_W     = fts_pkg::WLEN_W;
  localparam int ELAPSED_W  = fts_pkg::ELAPSED_W;
  localparam int FRAMES_W   = fts_pkg::FRAMES_W;
  localparam int COUNT_W    = fts_pkg::COUNT_W;
  localparam int NUM_COUNTS = fts_pkg::NUM_COUNTS;
  localparam int PADDR_W    = fts_pkg::PADDR_W;
  localparam int PDATA_W    = fts_pkg::PDATA_W;

  localparam logic [WLEN_W-1:0]  WLEN_RESET = fts_pkg::WLEN_RESET;
  localparam logic [FIELD_W-1:0] UPD_RESET  = fts_pkg::UPD_RESET;

  typedef fts_pkg::fts_in_t  fts_in_t;
  typedef fts_pkg::fts_out_t fts_out_t;

  localparam int MAX_WINDOW       = 64;
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int CYCLE_LIMIT      = 2000000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int DRAIN_CYCLES     = 40;
  localparam int NUM_PHASES       = 10;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
  localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_W) - 1;
  localparam longint unsigned FRAMES_MAX  = (64'd1 << FRAMES_W) - 1;
  localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_W) - 1;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH   = {fts_pkg::REG_WINDOW_LENGTH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UPDATE_INTERVAL = {fts_pkg::REG_UPDATE_INTERVAL, 2'b00};

  typedef struct {
    bit                 set_cfg;
    logic [WLEN_W-1:0]  wlen;
    logic [FIELD_W-1:0] upd;
    fts_in_t            ev;
    bit                 typed;
    fts_out_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  fts_in_if  frame_if ();
  fts_out_if stats_if ();

  frame_time_window_stats #(
    .MAX_WINDOW      (MAX_WINDOW),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .frame  (frame_if),
    .stats  (stats_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state: boxcar window and interval accumulators
  logic [FIELD_W-1:0] win_store [MAX_WINDOW];
  int unsigned        win_head = 0;
  int unsigned        win_fill = 0;
  longint unsigned    win_sum = 0;
  longint unsigned    acc_elapsed = 0;
  longint unsigned    acc_frames = 0;
  longint unsigned    acc_cnt [NUM_COUNTS] = '{default: 0};
  logic [WLEN_W-1:0]  cfg_wlen = WLEN_RESET;
  logic [FIELD_W-1:0] cfg_upd = UPD_RESET;

  fts_out_t pending_stats [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  int       events_sent = 0;
  int       results_checked = 0;
  int       updates_seen = 0;
  int       settings_used = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned max);
    return (a + b > max) ? max : a + b;
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input longint unsigned v);
    return (v > FIELD_MAX) ? FIELD_MAX : v[FIELD_W-1:0];
  endfunction

  function automatic fts_out_t compute_frame_stats(input fts_in_t ev);
    int unsigned        eff_len;
    int unsigned        slot;
    longint unsigned    rate;
    logic [FIELD_W-1:0] cnt_in [NUM_COUNTS];
    longint unsigned    avg [NUM_COUNTS];
    fts_out_t           r;
    eff_len = (cfg_wlen == 0) ? 1 : (cfg_wlen > MAX_WINDOW) ? MAX_WINDOW : cfg_wlen;
    // shrinking the window drops the oldest entries until one slot is free
    while (win_fill >= eff_len && win_fill > 0) begin
      win_sum -= win_store[win_head];
      win_head = (win_head + 1) % MAX_WINDOW;
      win_fill--;
    end
    slot = (win_head + win_fill) % MAX_WINDOW;
    win_store[slot] = ev.frame_time;
    win_fill++;
    win_sum += ev.frame_time;
    r = '0;
    r.window_mean_time = sat_field(win_sum / win_fill);

    cnt_in = '{ev.polygon_count, ev.line_count, ev.ttf_count, ev.stf_count,
               ev.point_count};
    acc_elapsed = sat_add(acc_elapsed, ev.gap_time, ELAPSED_MAX);
    acc_frames  = sat_add(acc_frames, 1, FRAMES_MAX);
    for (int i = 0; i < NUM_COUNTS; i++) acc_cnt[i] = sat_add(acc_cnt[i], cnt_in[i], COUNT_MAX);

    // strictly greater, so an interval of zero still needs some elapsed time
    if (acc_elapsed > cfg_upd) begin
      rate = (64'd16 * 64'(TICKS_PER_SECOND) * acc_frames) / acc_elapsed;
      for (int i = 0; i < NUM_COUNTS; i++) begin
        avg[i] = acc_cnt[i] / acc_frames;
        acc_cnt[i] = 0;
      end
      r.update_valid        = 1'b1;
      r.interval_frame_time = sat_field(acc_elapsed / acc_frames);
      r.frame_rate_x16      = (rate > 64'hFFFF) ? 16'hFFFF : rate[RATE_W-1:0];
      r.avg_polygons        = sat_field(avg[0]);
      r.avg_lines           = sat_field(avg[1]);
      r.avg_ttfs            = sat_field(avg[2]);
      r.avg_stfs            = sat_field(avg[3]);
      r.avg_points          = sat_field(avg[4]);
      acc_elapsed = 0;
      acc_frames  = 0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: every transfer is matched against the oldest prediction
  always @(posedge clk) begin : check_results
    fts_out_t want;
    fts_out_t got;
    if (!rst && stats_if.valid === 1'b1 && stats_if.ready === 1'b1) begin
      got = stats_if.data;
      if (pending_stats.size() == 0) begin
        $error("result transfer with no frame event outstanding");
        mismatches++;
      end else begin
        want = pending_stats[0];
        pending_stats.delete(0);
        results_checked++;
        if (got.update_valid === 1'b1) updates_seen++;
        check_field("window_mean_time", want.window_mean_time, got.window_mean_time);
        check_field("update_valid", want.update_valid, got.update_valid);
        check_field("interval_frame_time", want.interval_frame_time, got.interval_frame_time);
        check_field("frame_rate_x16", want.frame_rate_x16, got.frame_rate_x16);
        check_field("avg_polygons", want.avg_polygons, got.avg_polygons);
        check_field("avg_lines", want.avg_lines, got.avg_lines);
        check_field("avg_ttfs", want.avg_ttfs, got.avg_ttfs);
        check_field("avg_stfs", want.avg_stfs, got.avg_stfs);
        check_field("avg_points", want.avg_points, got.avg_points);
      end
    end
  end

  always @(posedge clk) begin
    stats_if.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frame_time_window_stats: mismatch");
      $finish;
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change once the block has delivered everything outstanding
  task automatic apply_settings(input logic [WLEN_W-1:0] wlen, input logic [FIELD_W-1:0] upd);
    logic [PDATA_W-1:0] rd;
    frame_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(ADDR_WINDOW_LENGTH, PDATA_W'(wlen));
    reg_write(ADDR_UPDATE_INTERVAL, PDATA_W'(upd));
    reg_read(ADDR_WINDOW_LENGTH, rd);
    check_field("window_length readback", wlen, rd[WLEN_W-1:0]);
    reg_read(ADDR_UPDATE_INTERVAL, rd);
    check_field("update_interval readback", upd, rd[FIELD_W-1:0]);
    cfg_wlen = wlen;
    cfg_upd  = upd;
    settings_used++;
  endtask

  task automatic send_event(input fts_in_t ev, input bit typed, input fts_out_t want);
    fts_out_t pred;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid <= 1'b1;
    frame_if.data  <= ev;
    do @(posedge clk); while (frame_if.ready !== 1'b1);
    pred = compute_frame_stats(ev);
    pending_stats.insert(pending_stats.size(), typed ? want : pred);
    events_sent++;
  endtask

  function automatic fts_in_t make_event(input logic [FIELD_W-1:0] ft, gap, poly, lines,
                                         ttf, stf, pts);
    fts_in_t ev;
    ev = '{ft, gap, poly, lines, ttf, stf, pts};
    return ev;
  endfunction

  function automatic fts_out_t make_stats(input logic [FIELD_W-1:0] mean,
                                          input logic uv,
                                          input logic [FIELD_W-1:0] ift,
                                          input logic [RATE_W-1:0] rate,
                                          input logic [FIELD_W-1:0] avg);
    fts_out_t s;
    s = '{mean, uv, ift, rate, avg, avg, avg, avg, avg};
    return s;
  endfunction

  function automatic void add_row(input bit set_cfg, input logic [WLEN_W-1:0] wlen,
                                  input logic [FIELD_W-1:0] upd, input fts_in_t ev,
                                  input bit typed, input fts_out_t want);
    dir_row_t row;
    row.set_cfg = set_cfg;
    row.wlen    = wlen;
    row.upd     = upd;
    row.ev      = ev;
    row.typed   = typed;
    row.want    = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic logic [FIELD_W-1:0] pick_count();
    case ($urandom_range(7))
      0: return '0;
      1: return FIELD_MAX;
      2, 3: return FIELD_W'($urandom_range(0, 4095));
      default: return FIELD_W'($urandom_range(0, FIELD_MAX));
    endcase
  endfunction

  function automatic fts_in_t random_event();
    logic [FIELD_W-1:0] ft;
    logic [FIELD_W-1:0] gap;
    case ($urandom_range(9))
      0: ft = '0;
      1: ft = FIELD_MAX;
      2, 3, 4: ft = FIELD_W'($urandom_range(1000, 50000));
      default: ft = FIELD_W'($urandom_range(0, FIELD_MAX));
    endcase
    // gaps mostly a fraction of the interval so updates come every few frames
    case ($urandom_range(9))
      0: gap = '0;
      1: gap = FIELD_W'($urandom_range(0, FIELD_MAX));
      2: gap = FIELD_MAX;
      default: gap = FIELD_W'($urandom_range(0, cfg_upd / 4 + 1));
    endcase
    return make_event(ft, gap, pick_count(), pick_count(), pick_count(), pick_count(),
                      pick_count());
  endfunction

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
      default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
    endcase
  endtask

  initial begin
    logic [PDATA_W-1:0] rd;
    logic [WLEN_W-1:0]  ph_wlen [NUM_PHASES];
    logic [FIELD_W-1:0] ph_upd [NUM_PHASES];
    int                 ph_items [NUM_PHASES];
    fts_out_t           quiet;

    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    frame_if.valid <= 1'b0;
    frame_if.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_read(ADDR_WINDOW_LENGTH, rd);
    check_field("window_length reset", WLEN_RESET, rd[WLEN_W-1:0]);
    reg_read(ADDR_UPDATE_INTERVAL, rd);
    check_field("update_interval reset", UPD_RESET, rd[FIELD_W-1:0]);

    quiet = '0;
    // reset settings: first event, extremes, interval boundary, first update
    add_row(0, 0, 0, make_event(100, 0, 0, 0, 0, 0, 0), 1, make_stats(100, 0, 0, 0, 0));
    add_row(0, 0, 0, make_event(FIELD_MAX, 0, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                                FIELD_MAX), 0, quiet);
    add_row(0, 0, 0, make_event(0, 333000, 1, 1, 1, 1, 1), 0, quiet);
    add_row(0, 0, 0, make_event(0, 1, 0, 0, 0, 0, 0), 0, quiet);
    // window of one, zero interval: shrink drops stored entries, rate saturates
    add_row(1, 1, 0, make_event(500, 0, 0, 0, 0, 0, 0), 1, make_stats(500, 0, 0, 0, 0));
    add_row(0, 0, 0, make_event(7, 1, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX),
            1, make_stats(7, 1, 0, 16'hFFFF, 24'h7FFFFF));
    // length zero acts as one; largest interval and largest gaps
    add_row(1, 0, FIELD_MAX, make_event(24'hABCDEF, FIELD_MAX, 0, 0, 0, 0, 0), 1,
            make_stats(24'hABCDEF, 0, 0, 0, 0));
    add_row(0, 0, 0, make_event(24'h123456, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX,
                                FIELD_MAX, FIELD_MAX),
            1, make_stats(24'h123456, 1, FIELD_MAX, 0, 24'h7FFFFF));
    // length above the store size clamps
    add_row(1, 127, 1, make_event(FIELD_MAX, 2, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
                                  24'h555555, 24'hAAAAAA), 0, quiet);
    add_row(0, 0, 0, make_event(FIELD_MAX, 0, 24'h555555, 24'hAAAAAA, 24'h555555,
                                24'hAAAAAA, 24'h555555), 0, quiet);
    add_row(0, 0, 0, make_event(1, 1, 3, 5, 7, 11, 13), 0, quiet);
    add_row(1, 64, 333000, make_event(800000, 100000, 40, 50, 60, 70, 80), 0, quiet);
    add_row(0, 0, 0, make_event(24'h800000, 200000, 9, 8, 7, 6, 5), 0, quiet);
    add_row(1, 2, 333000, make_event(3, 100000, 1, 2, 3, 4, 5), 0, quiet);
    add_row(0, 0, 0, make_event(24'h0F0F0F, 24'h0F0F0F, 24'hF0F0F0, 24'h0F0F0F, 24'hF0F0F0,
                                24'h0F0F0F, 24'hF0F0F0), 0, quiet);
    add_row(1, 65, 0, make_event(0, 0, 0, 0, 0, 0, 0), 0, quiet);
    add_row(0, 0, 0, make_event(FIELD_MAX, 0, FIELD_MAX, 0, FIELD_MAX, 0, FIELD_MAX), 0, quiet);
    add_row(0, 0, 0, make_event(42, 1, 1, 1, 1, 1, 1), 0, quiet);

    set_idling(0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) apply_settings(dir_rows[i].wlen, dir_rows[i].upd);
      send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    end

    // full window first so the next phase shrinks it from the top
    ph_wlen = '{64, 1, 10, 0, 127, 2, WLEN_W'($urandom_range(0, 127)), 64, 17,
                WLEN_W'($urandom_range(0, 127))};
    ph_upd  = '{333000, 0, FIELD_MAX, 1, 40000, FIELD_W'($urandom_range(0, FIELD_MAX)),
                333000, 1000, FIELD_W'($urandom_range(0, FIELD_MAX)), FIELD_MAX};
    ph_items = '{90, 50, 50, 50, 55, 50, 50, 55, 50, 50};
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_settings(ph_wlen[p], ph_upd[p]);
      set_idling(p % 4);
      repeat (ph_items[p]) send_event(random_event(), 0, quiet);
    end

    frame_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d frame events, %0d results checked, %0d of them interval updates",
             events_sent, results_checked, updates_seen);
    $display("%0d register settings incl. zero, clamped and full-scale lengths and intervals",
             settings_used);
    if (mismatches == 0) begin
      $display("frame_time_window_stats: match");
    end else begin
      $display("frame_time_window_stats: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/fts_pkg.sv
hdl/fts_if.sv
hdl/fts_ram.sv
hdl/fts_div.sv
hdl/frame_time_window_stats.sv
verif/tb_top.sv
